@@ hdl/bev_pkg.sv @@
// ----------------------------------------------------------------------------
// bev_pkg: shared types and constants
// Widths, item codes and vertex record for the back-face edge marking block.
// ----------------------------------------------------------------------------
`default_nettype none
package bev_pkg;
    localparam int VERTEX_SLOTS = 1024;
    localparam int LINE_SLOTS   = 2048;
    localparam int COORD_BITS   = 24;
    localparam int VIDX_BITS    = $clog2(VERTEX_SLOTS);
    localparam int LIDX_BITS    = $clog2(LINE_SLOTS);
    // widths of the exact integer chain
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int CTR_BITS     = COORD_BITS + 2;
    localparam int PROD_BITS    = 2 * DIFF_BITS;
    localparam int NRM_BITS     = PROD_BITS + 1;
    // normal split into two halves for the dot product multiplier
    localparam int NRM_LO_BITS  = NRM_BITS / 2;
    localparam int NRM_HI_BITS  = NRM_BITS - NRM_LO_BITS;

    typedef logic [1:0] t_func;
    localparam t_func FUNC_LOAD = 2'd0;
    localparam t_func FUNC_TEST = 2'd1;
    localparam t_func FUNC_READ = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } t_vertex;

    // corner data handed to the dot product unit
    typedef struct packed {
        logic    go;
        t_vertex a;
        t_vertex b;
        t_vertex c;
    } t_tri;
endpackage
`default_nettype wire

@@ hdl/bev_dot.sv @@
// ----------------------------------------------------------------------------
// bev_dot: triangle facing test
// Sequential unit: forms (b-a)x(c-a) . (a+b+2c), one product or half product
// per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module bev_dot (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire bev_pkg::t_tri  i_tri,
    output logic                o_done,
    output logic                o_back
);
    import bev_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_CROSS, S_DOT, S_SIGN} t_state;

    t_state r_state;
    logic [2:0] r_step;
    logic signed [DIFF_BITS-1:0] r_u [3];
    logic signed [DIFF_BITS-1:0] r_v [3];
    logic signed [CTR_BITS-1:0]  r_ctr [3];
    logic signed [NRM_BITS-1:0]  r_n [3];
    logic signed [PROD_BITS-1:0] r_p;
    logic signed [NRM_BITS+CTR_BITS+1:0] r_acc;
    logic signed [DIFF_BITS-1:0] m_a, m_b;
    logic signed [PROD_BITS-1:0] m_p;
    logic signed [NRM_BITS-1:0]  d_n;
    logic signed [CTR_BITS-1:0]  d_c;
    logic signed [NRM_HI_BITS-1:0] d_hi;
    logic signed [NRM_LO_BITS:0]   d_lo;
    logic signed [NRM_HI_BITS+CTR_BITS-1:0]   d_ph;
    logic signed [NRM_LO_BITS+1+CTR_BITS-1:0] d_pl;
    logic signed [NRM_BITS+CTR_BITS+1:0] d_p;

    // cross product operand select: steps 0..5 give uy*vz, uz*vy, uz*vx, ux*vz, ux*vy, uy*vx
    always_comb begin
        case (r_step)
            3'd0: begin m_a = r_u[1]; m_b = r_v[2]; end
            3'd1: begin m_a = r_u[2]; m_b = r_v[1]; end
            3'd2: begin m_a = r_u[2]; m_b = r_v[0]; end
            3'd3: begin m_a = r_u[0]; m_b = r_v[2]; end
            3'd4: begin m_a = r_u[0]; m_b = r_v[1]; end
            default: begin m_a = r_u[1]; m_b = r_v[0]; end
        endcase
        m_p = m_a * m_b;
        // dot steps 0..5: term r_step/2, low half on even steps, high half on odd
        d_n  = r_n[r_step[2:1]];
        d_c  = r_ctr[r_step[2:1]];
        d_hi = d_n[NRM_BITS-1:NRM_LO_BITS];
        d_lo = {1'b0, d_n[NRM_LO_BITS-1:0]};
        d_ph = d_hi * d_c;
        d_pl = d_lo * d_c;
        if (r_step[0]) begin
            d_p = $bits(d_p)'(d_ph) <<< NRM_LO_BITS;
        end else begin
            d_p = $bits(d_p)'(d_pl);
        end
    end

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            o_back  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_tri.go) begin
                        r_u[0] <= DIFF_BITS'(i_tri.b.x) - DIFF_BITS'(i_tri.a.x);
                        r_u[1] <= DIFF_BITS'(i_tri.b.y) - DIFF_BITS'(i_tri.a.y);
                        r_u[2] <= DIFF_BITS'(i_tri.b.z) - DIFF_BITS'(i_tri.a.z);
                        r_v[0] <= DIFF_BITS'(i_tri.c.x) - DIFF_BITS'(i_tri.a.x);
                        r_v[1] <= DIFF_BITS'(i_tri.c.y) - DIFF_BITS'(i_tri.a.y);
                        r_v[2] <= DIFF_BITS'(i_tri.c.z) - DIFF_BITS'(i_tri.a.z);
                        r_ctr[0] <= CTR_BITS'(i_tri.a.x) + CTR_BITS'(i_tri.b.x)
                                  + (CTR_BITS'(i_tri.c.x) <<< 1);
                        r_ctr[1] <= CTR_BITS'(i_tri.a.y) + CTR_BITS'(i_tri.b.y)
                                  + (CTR_BITS'(i_tri.c.y) <<< 1);
                        r_ctr[2] <= CTR_BITS'(i_tri.a.z) + CTR_BITS'(i_tri.b.z)
                                  + (CTR_BITS'(i_tri.c.z) <<< 1);
                        r_step  <= '0;
                        r_state <= S_CROSS;
                    end
                end
                S_CROSS: begin
                    // even step stores first term, odd step subtracts second
                    if (!r_step[0]) begin
                        r_p <= m_p;
                    end else begin
                        r_n[r_step[2:1]] <= NRM_BITS'(r_p) - NRM_BITS'(m_p);
                    end
                    if (r_step == 3'd5) begin
                        r_step  <= '0;
                        r_acc   <= '0;
                        r_state <= S_DOT;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_DOT: begin
                    r_acc <= r_acc + d_p;
                    if (r_step == 3'd5) begin
                        r_state <= S_SIGN;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_SIGN: begin
                    o_back  <= r_acc[$bits(r_acc)-1];
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ hdl/backface_edge_visibility.sv @@
// ----------------------------------------------------------------------------
// backface_edge_visibility: back-face culling with mesh line marking
// Vertex store, line flag store and the facing test around them.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------
//  command  | i_start / o_busy        | i_func, i_vertex_index, i_pos_*,
//           |                         | i_corner_*, i_edge_*
//  result   | o_strobe (one cycle)    | o_back_facing, o_line_visible
//
//  A command is taken when i_start is high and o_busy low; one item at a time.
//  Steps below run from one accepted word to the next possible accept.
//  Load: vertex write, result. Read line: flag memory read, clear, result.
//  Triangle: vertex reads, the facing unit (6 cross, 6 dot half products,
//  handoff), up to 3 flag writes when back-facing, then the result.
//  Reset sweeps all LINE_SLOTS (2048) flags to zero, busy high.
//  The result strobe cannot be stalled; busy drops in the same cycle as it.
// ----------------------------------------------------------------------------
`default_nettype none
module backface_edge_visibility (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_start,
    output logic                                 o_busy,
    input  wire  [1:0]                           i_func,
    input  wire  [9:0]                           i_vertex_index,
    input  wire  signed [bev_pkg::COORD_BITS-1:0] i_pos_x,
    input  wire  signed [bev_pkg::COORD_BITS-1:0] i_pos_y,
    input  wire  signed [bev_pkg::COORD_BITS-1:0] i_pos_z,
    input  wire  [9:0]                           i_corner_a,
    input  wire  [9:0]                           i_corner_b,
    input  wire  [9:0]                           i_corner_c,
    input  wire  [10:0]                          i_edge_a,
    input  wire  [10:0]                          i_edge_b,
    input  wire  [10:0]                          i_edge_c,
    output logic                                 o_strobe,
    output logic                                 o_back_facing,
    output logic                                 o_line_visible
);
    import bev_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_VRD_A, S_VRD_B, S_VRD_C, S_VWAIT, S_TEST,
        S_SET_A, S_SET_B, S_SET_C, S_LRD, S_LCLR, S_DONE
    } t_state;

    // vertex store: one word per slot (x, y, z), undefined until loaded
    t_vertex r_vmem [VERTEX_SLOTS];
    // line flags: one bit per line, cleared by the reset sweep
    logic    r_lmem [LINE_SLOTS];

    t_state r_state;
    logic [LIDX_BITS:0] r_clr;
    t_func r_func;
    logic [VIDX_BITS-1:0] r_ca, r_cb, r_cc;
    logic [LIDX_BITS-1:0] r_ea, r_eb, r_ec;
    t_vertex r_va, r_vb;
    t_vertex r_vrd;
    logic    r_lrd;
    t_tri    r_tri;
    logic    dot_done, dot_back;

    // memory ports: one write, one registered read each
    logic                 vm_we;
    logic [VIDX_BITS-1:0] vm_waddr, vm_raddr;
    t_vertex              vm_wdata;
    logic                 lm_we, lm_wdata;
    logic [LIDX_BITS-1:0] lm_addr;

    always_ff @(posedge i_clk) begin
        if (vm_we) begin
            r_vmem[vm_waddr] <= vm_wdata;
        end
        r_vrd <= r_vmem[vm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (lm_we) begin
            r_lmem[lm_addr] <= lm_wdata;
        end
        r_lrd <= r_lmem[lm_addr];
    end

    bev_dot u_dot (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_tri  (r_tri),
        .o_done (dot_done),
        .o_back (dot_back)
    );

    wire accept = i_start && (r_state == S_IDLE);

    always_comb begin
        vm_we    = accept && (i_func == FUNC_LOAD);
        vm_waddr = i_vertex_index[VIDX_BITS-1:0];
        vm_wdata = '{x: i_pos_x, y: i_pos_y, z: i_pos_z};
        case (r_state)
            S_VRD_A: vm_raddr = r_ca;
            S_VRD_B: vm_raddr = r_cb;
            default: vm_raddr = r_cc;
        endcase
        lm_we    = 1'b0;
        lm_wdata = 1'b0;
        case (r_state)
            S_CLEAR: begin
                lm_we   = 1'b1;
                lm_addr = r_clr[LIDX_BITS-1:0];
            end
            S_SET_A: begin lm_we = 1'b1; lm_wdata = 1'b1; lm_addr = r_ea; end
            S_SET_B: begin lm_we = 1'b1; lm_wdata = 1'b1; lm_addr = r_eb; end
            S_SET_C: begin lm_we = 1'b1; lm_wdata = 1'b1; lm_addr = r_ec; end
            S_LCLR:  begin lm_we = 1'b1; lm_addr = r_ea; end
            default: lm_addr = r_ea;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr          <= '0;
            r_tri.go       <= 1'b0;
            o_strobe       <= 1'b0;
            o_back_facing  <= 1'b0;
            o_line_visible <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            r_tri.go <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (LIDX_BITS+1)'(LINE_SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_func <= i_func;
                        r_ca <= i_corner_a[VIDX_BITS-1:0];
                        r_cb <= i_corner_b[VIDX_BITS-1:0];
                        r_cc <= i_corner_c[VIDX_BITS-1:0];
                        r_ea <= i_edge_a[LIDX_BITS-1:0];
                        r_eb <= i_edge_b[LIDX_BITS-1:0];
                        r_ec <= i_edge_c[LIDX_BITS-1:0];
                        case (i_func)
                            FUNC_TEST: r_state <= S_VRD_A;
                            FUNC_READ: r_state <= S_LRD;
                            default:   r_state <= S_DONE;
                        endcase
                    end
                end
                S_VRD_A: r_state <= S_VRD_B;
                S_VRD_B: begin
                    r_va    <= r_vrd;
                    r_state <= S_VRD_C;
                end
                S_VRD_C: begin
                    r_vb    <= r_vrd;
                    r_state <= S_VWAIT;
                end
                S_VWAIT: begin
                    r_tri.a <= r_va;
                    r_tri.b <= r_vb;
                    r_tri.c <= r_vrd;
                    r_tri.go <= 1'b1;
                    r_state <= S_TEST;
                end
                S_TEST: begin
                    if (dot_done) begin
                        r_state <= dot_back ? S_SET_A : S_DONE;
                    end
                end
                S_SET_A: r_state <= S_SET_B;
                S_SET_B: r_state <= S_SET_C;
                S_SET_C: r_state <= S_DONE;
                S_LRD:   r_state <= S_LCLR;
                S_LCLR:  r_state <= S_DONE;
                S_DONE: begin
                    o_strobe       <= 1'b1;
                    o_back_facing  <= (r_func == FUNC_TEST) && dot_back;
                    o_line_visible <= (r_func == FUNC_READ) && r_lrd;
                    r_state        <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
